>>> design/mwst_pkg.sv
// Shared types and fixed constants for the max window spread tracker.
// Used by mwst_cell and max_window_spread_tracker_core; depends on nothing else.

package mwst_pkg;

	localparam int SAMPLE_BITS = 31;
	localparam int LEN_BITS    = 11;
	localparam logic [LEN_BITS-1:0] LEN_RESET = 11'd1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [LEN_BITS-1:0]    win_len_t;

	typedef struct packed {
		sample_t sample_value;
		logic    last_sample;
	} sample_item_t;

	typedef struct packed {
		sample_t max_spread;
		logic    full_window_seen;
	} result_item_t;

	// Running extremes of the newest samples, handed from one cell to the next.
	typedef struct packed {
		logic    vld;
		sample_t hi;
		sample_t lo;
	} win_link_t;

	// Spread of a finished window, travelling back toward cell zero.
	typedef struct packed {
		logic    seen;
		sample_t spread;
	} spread_link_t;

endpackage

>>> design/mwst_cell.sv
// One cell of the window chain: extremes of the newest IDX+1 samples and one
// stage of the spread return line. Depends on mwst_pkg.

module mwst_cell #(
	parameter int IDX  = 0,
	parameter int IDXW = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  logic                  first,
	input  mwst_pkg::sample_t     sample,
	input  mwst_pkg::win_link_t   win_in,
	output mwst_pkg::win_link_t   win_out,
	input  logic                  fire,
	input  logic [IDXW-1:0]       fire_idx,
	input  mwst_pkg::spread_link_t sp_in,
	output mwst_pkg::spread_link_t sp_out
);
	import mwst_pkg::*;

	win_link_t    win_q;
	win_link_t    win_d;
	spread_link_t sp_q;
	spread_link_t sp_d;
	logic         inject;
	sample_t      own_spread;

	// Cell zero starts a fresh window with the new sample; the others widen the
	// window of their left neighbor by that sample.
	always_comb begin
		if (IDX == 0) begin
			win_d.vld = 1'b1;
			win_d.hi  = sample;
			win_d.lo  = sample;
		end else begin
			win_d.vld = win_in.vld & ~first;
			win_d.hi  = (win_in.hi > sample) ? win_in.hi : sample;
			win_d.lo  = (win_in.lo < sample) ? win_in.lo : sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift_en) begin
			win_q <= win_d;
		end
	end

	// The cell whose span equals the window length reports its spread.
	assign inject     = fire & win_q.vld & (fire_idx == IDXW'(IDX));
	assign own_spread = win_q.hi - win_q.lo;

	always_comb begin
		sp_d.seen   = sp_in.seen | inject;
		sp_d.spread = sp_in.spread;
		if (inject && (own_spread > sp_in.spread)) begin
			sp_d.spread = own_spread;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			sp_q <= sp_d;
		end
	end

	assign win_out = win_q;
	assign sp_out  = sp_q;

endmodule

>>> design/max_window_spread_tracker_core.sv
// Top level of the max window spread tracker: a chain of mwst_cell instances,
// the configuration register and the result register. Depends on mwst_pkg, mwst_cell.
//
//   channel   direction  payload            handshake
//   sample    in         sample_item_t      sample_valid / sample_ready
//   result    out        result_item_t      result_valid / result_ready
//   cfg       in         window length      cfg_valid / cfg_ready
//
// Within a series one sample transaction is taken in every cycle; the chain of
// cells updates all window extremes for all spans at once when a sample lands.
// After the last sample of a series the spread return line must empty before the
// result is registered; a longer window closed by one of the samples just before it
// can delay this further. No sample is taken until the result is registered, and an
// earlier result still stalled on the output delays that.
// Reset clears the window valid bits, the return line and all control state but fire_len_s1.
// A stalled result sits in its own register while the next series is taken.

module max_window_spread_tracker_core #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  mwst_pkg::sample_item_t sample_data,
	output logic                  result_valid,
	input  logic                  result_ready,
	output mwst_pkg::result_item_t result_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  mwst_pkg::win_len_t    cfg_data
);
	import mwst_pkg::*;

	localparam int IDXW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNTW = $clog2(MAX_WINDOW + 1);
	localparam int CMPW = (CNTW > LEN_BITS) ? CNTW : LEN_BITS;
	localparam logic [CMPW-1:0] MAX_LEN_W = CMPW'(MAX_WINDOW);

	// Configuration register. The user must write it only while the block is idle; the block does not enforce this.
	win_len_t len_q;
	logic [CMPW-1:0] len_wide;
	logic [CNTW-1:0] len_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_valid) begin
			len_q <= cfg_data;
		end
	end

	// A zero length behaves as one, and lengths past the chain saturate.
	always_comb begin
		len_wide = CMPW'(len_q);
		if (len_wide == '0) begin
			len_eff = CNTW'(1);
		end else if (len_wide > MAX_LEN_W) begin
			len_eff = CNTW'(MAX_WINDOW);
		end else begin
			len_eff = len_wide[CNTW-1:0];
		end
	end

	// Series control.
	logic            accept;
	logic            first_q;
	logic            pend_q;
	logic            fire_s1;
	logic [CNTW-1:0] fire_len_s1;
	logic [IDXW-1:0] fire_idx;
	logic [CNTW-1:0] drain_q;
	logic [CNTW-1:0] drain_dec;
	logic            load;
	sample_t         best_q;
	logic            full_q;
	logic            result_valid_q;
	result_item_t    result_q;

	assign sample_ready = ~pend_q;
	assign accept       = sample_valid & sample_ready;
	assign fire_idx     = IDXW'(fire_len_s1 - CNTW'(1));

	// The length is taken with the sample, so the window that this sample closes
	// uses the length in force when it arrived.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_s1 <= 1'b0;
		end else begin
			fire_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fire_len_s1 <= len_eff;
		end
	end

	// Chain of cells. Window extremes move away from cell zero with each sample;
	// finished spreads move toward cell zero one cell per cycle.
	win_link_t    win_link [MAX_WINDOW];
	spread_link_t sp_link  [MAX_WINDOW];

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		win_link_t    win_prev;
		spread_link_t sp_next;

		if (i == 0) begin : g_head
			assign win_prev = '0;
		end else begin : g_body
			assign win_prev = win_link[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_tail
			assign sp_next = '0;
		end else begin : g_inner
			assign sp_next = sp_link[i+1];
		end

		mwst_cell #(
			.IDX  (i),
			.IDXW (IDXW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.first    (first_q),
			.sample   (sample_data.sample_value),
			.win_in   (win_prev),
			.win_out  (win_link[i]),
			.fire     (fire_s1),
			.fire_idx (fire_idx),
			.sp_in    (sp_next),
			.sp_out   (sp_link[i])
		);
	end

	// The drain counter holds how many cycles remain until every spread in
	// flight has reached the best-spread register.
	assign drain_dec = (drain_q == '0) ? '0 : drain_q - CNTW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= '0;
		end else if (fire_s1 && (fire_len_s1 > drain_dec)) begin
			drain_q <= fire_len_s1;
		end else begin
			drain_q <= drain_dec;
		end
	end

	// The result is registered once the last sample has been through the chain
	// and the output register is free.
	assign load = pend_q & ~fire_s1 & (drain_q == '0) & (~result_valid_q | result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			pend_q  <= 1'b0;
			best_q  <= '0;
			full_q  <= 1'b0;
		end else begin
			if (accept) begin
				first_q <= 1'b0;
				pend_q  <= sample_data.last_sample;
			end else if (load) begin
				first_q <= 1'b1;
				pend_q  <= 1'b0;
			end
			if (load) begin
				best_q <= '0;
				full_q <= 1'b0;
			end else begin
				if (sp_link[0].spread > best_q) begin
					best_q <= sp_link[0].spread;
				end
				full_q <= full_q | sp_link[0].seen;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.max_spread       <= best_q;
			result_q.full_window_seen <= full_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

`ifndef ASSERT_OFF
	a_no_window_no_spread: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.full_window_seen |-> result_q.max_spread == '0)
		else $error("spread reported without a full window");

	a_fire_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |-> $past(sample_valid && sample_ready))
		else $error("window evaluation without a sample transaction");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(drain_q == '0 && !fire_s1 && pend_q))
		else $error("result registered before the return line drained");
`endif

endmodule
